[hw/rtl/pcd_pkg.sv]
// ----------------------------------------------------------------------------
// pcd_pkg: shared types and constants of the pcap capture deframer
// Phase and status codes, header layout, scaling constants and queue command.
// ----------------------------------------------------------------------------
package pcd_pkg;

  localparam logic [31:0] PcapMagic     = 32'hA1B2C3D4;
  localparam logic [31:0] ResetLinkType = 32'd1;
  localparam int          GlobalHdrLen  = 24;
  localparam int          RecordHdrLen  = 16;
  localparam int          MsScale       = 1000;

  localparam int IdxW = 5;
  localparam int TsW  = 42;

  // floor(x / 1000) for any 32-bit x: (x * UsecRecip) >> UsecShift
  localparam logic [28:0] UsecRecip = 29'h10624DD3;
  localparam int          UsecShift = 38;
  localparam int          UsecProdW = 61;
  localparam int          UsecMsW   = 23;

  localparam int QueueDepth = 4;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    PH_GLOBAL,
    PH_RECHDR,
    PH_PAYLOAD,
    PH_DRAIN
  } pcd_phase_e;

  typedef enum logic [2:0] {
    ST_PAYLOAD = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_DONE    = 3'd2,
    ST_SMALL   = 3'd3,
    ST_MAGIC   = 3'd4,
    ST_LINK    = 3'd5,
    ST_TRUNC   = 3'd6
  } pcd_status_e;

  // One queued command: a first result, optionally followed by done or truncated.
  typedef struct packed {
    pcd_status_e        status;
    logic [7:0]         payload_byte;
    logic               first_of_record;
    logic               last_of_record;
    logic [TsW-1:0]     timestamp_ms;
    logic [31:0]        record_length;
    logic [31:0]        byte_offset;
    logic               has_second;
    logic               second_trunc;
  } pcd_cmd_t;

endpackage

[hw/rtl/pcd_byte_if.sv]
// ----------------------------------------------------------------------------
// pcd_byte_if: capture byte channel
// One file byte per item, with an end-of-file flag.
// ----------------------------------------------------------------------------
interface pcd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_file;

  modport source (output valid, output data_byte, output end_of_file, input ready);
  modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

[hw/rtl/pcd_cfg_if.sv]
// ----------------------------------------------------------------------------
// pcd_cfg_if: configuration write channel
// Carries the expected link type word.
// ----------------------------------------------------------------------------
interface pcd_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] expected_link_type;

  modport source (output valid, output expected_link_type, input ready);
  modport sink   (input valid, input expected_link_type, output ready);
endinterface

[hw/rtl/pcd_result_if.sv]
// ----------------------------------------------------------------------------
// pcd_result_if: deframer result channel
// Payload bytes with record context, plus status items.
// ----------------------------------------------------------------------------
interface pcd_result_if import pcd_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [2:0]     status;
  logic [7:0]     payload_byte;
  logic [TsW-1:0] timestamp_ms;
  logic           first_of_record;
  logic           last_of_record;
  logic [31:0]    record_length;
  logic [31:0]    byte_offset;
  logic           last_of_run;

  modport source (
    output valid, output status, output payload_byte, output timestamp_ms,
    output first_of_record, output last_of_record, output record_length,
    output byte_offset, output last_of_run, input ready
  );
  modport sink (
    input valid, input status, input payload_byte, input timestamp_ms,
    input first_of_record, input last_of_record, input record_length,
    input byte_offset, input last_of_run, output ready
  );
endinterface

[hw/rtl/pcap_capture_deframer.sv]
// ----------------------------------------------------------------------------
// pcap_capture_deframer: classic little-endian pcap stream parser
// Checks the global header, splits records and tags every payload byte.
// ----------------------------------------------------------------------------
// Takes one capture byte per clock cycle, flagged on the file's last byte.
// The 24-byte global header is checked for length, magic and the link type
// held in the configuration register (reset value 1, Ethernet). Each payload
// byte leaves with its record's millisecond timestamp, included length, file
// offset of the payload start and first/last marks; a zero-length record gives
// one empty-record item. End of file yields done, too small or truncated
// unless the header was rejected, and the next byte begins a new file. Most
// bytes yield no result or exactly one; a byte ending the file inside a
// payload or on the last header byte of a zero-length record yields two.
// Input is taken every cycle while the four-entry command queue has room,
// so the sustained rate is one byte per cycle as long as the sink takes one
// result per cycle. Results pass the command queue, then the output register.
module pcap_capture_deframer import pcd_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  pcd_cfg_if.sink       cfg_i,
  pcd_byte_if.sink      in_i,
  pcd_result_if.source  out_o
);

  // front -> queue
  logic     push;
  pcd_cmd_t push_cmd;
  logic     q_full;

  // queue -> back
  logic     head_valid;
  pcd_cmd_t head_cmd;
  logic     pop;

  // Front: header checks, record header capture, time scaling, classification.
  pcd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .cfg_i    (cfg_i),
    .q_full_i (q_full),
    .push_o   (push),
    .cmd_o    (push_cmd)
  );

  // Decouples parsing from output backpressure.
  pcd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_cmd_i   (push_cmd),
    .pop_i        (pop),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_o       (head_cmd)
  );

  // Back: expands a command into its result items, marks the run's last one.
  pcd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_cmd),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule

[hw/rtl/pcd_queue.sv]
// ----------------------------------------------------------------------------
// pcd_queue: command queue between parser front and result back end
// Small register FIFO; full stalls the front.
// ----------------------------------------------------------------------------
module pcd_queue import pcd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  pcd_cmd_t push_cmd_i,
  input  logic     pop_i,
  output logic     full_o,
  output logic     head_valid_o,
  output pcd_cmd_t head_o
);

  pcd_cmd_t         entry_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o       = (count_q == QCntW'(QueueDepth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = entry_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

[hw/rtl/pcd_front.sv]
// ----------------------------------------------------------------------------
// pcd_front: byte parser and classifier
// Tracks headers and payloads, builds one queue command per result run.
// ----------------------------------------------------------------------------
module pcd_front import pcd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  pcd_byte_if.sink in_i,
  pcd_cfg_if.sink  cfg_i,
  input  logic     q_full_i,
  output logic     push_o,
  output pcd_cmd_t cmd_o
);

  pcd_phase_e       phase_q, phase_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic             magic_bad_q, magic_bad_d;
  logic             link_bad_q, link_bad_d;
  logic [31:0]      offset_q, offset_d;
  logic [31:0]      link_type_q;

  logic [31:0]      sec_q, sec_d;
  logic [31:0]      usec_q, usec_d;
  logic [31:0]      len_q, len_d;
  logic [TsW-1:0]   rec_time_q, rec_time_d;
  logic [31:0]      remain_q, remain_d;
  logic [31:0]      pstart_q, pstart_d;
  logic [TsW-1:0]   sec_ms_q;
  logic [UsecMsW-1:0] usec_ms_q;
  logic [UsecProdW-1:0] usec_prod;

  logic             acc, eof, push_c;
  logic [7:0]       b, magic_byte, link_byte;
  logic             magic_bad, link_bad, glob_end, rec_end;
  logic             pay_first, pay_last;
  logic [31:0]      off_inc;
  logic [TsW-1:0]   rec_time_now;

  assign in_i.ready  = !q_full_i;
  assign cfg_i.ready = 1'b1;

  assign acc = in_i.valid && in_i.ready;
  assign b   = in_i.data_byte;
  assign eof = in_i.end_of_file;

  assign magic_byte = 8'(PcapMagic >> {idx_q[1:0], 3'b000});
  assign link_byte  = 8'(link_type_q >> {idx_q[1:0], 3'b000});
  // magic is bytes 0..3, link type bytes 20..23
  assign magic_bad = magic_bad_q || ((idx_q[4:2] == 3'b000) && (b != magic_byte));
  assign link_bad  = link_bad_q  || ((idx_q[4:2] == 3'b101) && (b != link_byte));
  assign glob_end  = (idx_q == IdxW'(GlobalHdrLen - 1));
  assign rec_end   = (idx_q == IdxW'(RecordHdrLen - 1));

  assign off_inc   = (offset_q == '1) ? offset_q : offset_q + 32'd1;
  assign pay_first = (remain_q == len_q);
  assign pay_last  = (remain_q <= 32'd1);

  // Time words settle by header byte 7; both products are ready long before byte 15.
  assign usec_prod    = UsecProdW'(usec_q) * UsecProdW'(UsecRecip);
  assign rec_time_now = sec_ms_q + TsW'(usec_ms_q);

  // next state
  always_comb begin
    phase_d     = phase_q;
    idx_d       = idx_q;
    magic_bad_d = magic_bad_q;
    link_bad_d  = link_bad_q;
    offset_d    = offset_q;
    sec_d       = sec_q;
    usec_d      = usec_q;
    len_d       = len_q;
    rec_time_d  = rec_time_q;
    remain_d    = remain_q;
    pstart_d    = pstart_q;
    if (acc) begin
      offset_d = off_inc;
      case (phase_q)
        PH_GLOBAL: begin
          magic_bad_d = magic_bad;
          link_bad_d  = link_bad;
          if (glob_end) begin
            if (magic_bad || link_bad) begin
              phase_d = PH_DRAIN;
            end else begin
              phase_d = PH_RECHDR;
              idx_d   = '0;
            end
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
        PH_RECHDR: begin
          case (idx_q[3:2])
            2'd0:    sec_d  = {b, sec_q[31:8]};
            2'd1:    usec_d = {b, usec_q[31:8]};
            2'd2:    len_d  = {b, len_q[31:8]};
            default: ;
          endcase
          if (rec_end) begin
            rec_time_d = rec_time_now;
            remain_d   = len_q;
            pstart_d   = off_inc;
            idx_d      = '0;
            if (len_q != '0) begin
              phase_d = PH_PAYLOAD;
            end
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
        PH_PAYLOAD: begin
          if (remain_q != '0) begin
            remain_d = remain_q - 32'd1;
          end
          if (pay_last) begin
            phase_d = PH_RECHDR;
            idx_d   = '0;
          end
        end
        default: ;
      endcase
      // every end of file starts over with a new capture
      if (eof) begin
        phase_d     = PH_GLOBAL;
        idx_d       = '0;
        magic_bad_d = 1'b0;
        link_bad_d  = 1'b0;
        offset_d    = '0;
      end
    end
  end

  // outputs
  always_comb begin
    push_c                = 1'b0;
    cmd_o.status          = ST_DONE;
    cmd_o.payload_byte    = '0;
    cmd_o.first_of_record = 1'b0;
    cmd_o.last_of_record  = 1'b0;
    cmd_o.timestamp_ms    = rec_time_q;
    cmd_o.record_length   = len_q;
    cmd_o.byte_offset     = pstart_q;
    cmd_o.has_second      = 1'b0;
    cmd_o.second_trunc    = 1'b0;
    case (phase_q)
      PH_GLOBAL: begin
        if (glob_end) begin
          if (magic_bad || link_bad) begin
            push_c       = 1'b1;
            cmd_o.status = magic_bad ? ST_MAGIC : ST_LINK;
          end else if (eof) begin
            push_c       = 1'b1;
            cmd_o.status = ST_DONE;
          end
        end else if (eof) begin
          push_c       = 1'b1;
          cmd_o.status = ST_SMALL;
        end
      end
      PH_RECHDR: begin
        if (rec_end) begin
          cmd_o.timestamp_ms  = rec_time_now;
          cmd_o.record_length = len_q;
          cmd_o.byte_offset   = off_inc;
          if (len_q == '0) begin
            push_c           = 1'b1;
            cmd_o.status     = ST_EMPTY;
            cmd_o.has_second = eof;
          end else if (eof) begin
            push_c       = 1'b1;
            cmd_o.status = ST_TRUNC;
          end
        end else if (eof) begin
          push_c       = 1'b1;
          cmd_o.status = ST_DONE;
        end
      end
      PH_PAYLOAD: begin
        push_c                = 1'b1;
        cmd_o.status          = ST_PAYLOAD;
        cmd_o.payload_byte    = b;
        cmd_o.first_of_record = pay_first;
        cmd_o.last_of_record  = pay_last;
        cmd_o.has_second      = eof;
        cmd_o.second_trunc    = !pay_last;
      end
      default: ;
    endcase
  end

  assign push_o = acc && push_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_GLOBAL;
      idx_q       <= '0;
      magic_bad_q <= 1'b0;
      link_bad_q  <= 1'b0;
      offset_q    <= '0;
      link_type_q <= ResetLinkType;
    end else begin
      phase_q     <= phase_d;
      idx_q       <= idx_d;
      magic_bad_q <= magic_bad_d;
      link_bad_q  <= link_bad_d;
      offset_q    <= offset_d;
      if (cfg_i.valid) begin
        link_type_q <= cfg_i.expected_link_type;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sec_q      <= sec_d;
    usec_q     <= usec_d;
    len_q      <= len_d;
    rec_time_q <= rec_time_d;
    remain_q   <= remain_d;
    pstart_q   <= pstart_d;
    sec_ms_q   <= TsW'(sec_q) * TsW'(MsScale);
    usec_ms_q  <= usec_prod[UsecShift +: UsecMsW];
  end

endmodule

[hw/rtl/pcd_back.sv]
// ----------------------------------------------------------------------------
// pcd_back: result expander and output register
// Turns each queued command into one or two result items.
// ----------------------------------------------------------------------------
module pcd_back import pcd_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           head_valid_i,
  input  pcd_cmd_t       head_i,
  output logic           pop_o,
  pcd_result_if.source   out_o
);

  logic           out_valid_q, out_valid_d;
  logic           second_q, second_d;
  pcd_status_e    status_q;
  logic [7:0]     byte_q;
  logic [TsW-1:0] ts_q;
  logic           first_q, last_q, run_last_q;
  logic [31:0]    len_q, off_q;

  logic           load, run_last, is_rec;
  pcd_status_e    sel_status;

  assign load       = head_valid_i && (!out_valid_q || out_o.ready);
  assign sel_status = !second_q ? head_i.status :
                      (head_i.second_trunc ? ST_TRUNC : ST_DONE);
  assign is_rec     = sel_status inside {ST_PAYLOAD, ST_EMPTY, ST_TRUNC};
  assign run_last   = second_q || !head_i.has_second;
  assign pop_o      = load && run_last;

  always_comb begin
    second_d    = second_q;
    out_valid_d = out_valid_q;
    if (load) begin
      second_d    = !second_q && head_i.has_second;
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      second_q    <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      second_q    <= second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      status_q   <= sel_status;
      byte_q     <= second_q ? 8'd0 : head_i.payload_byte;
      first_q    <= !second_q && head_i.first_of_record;
      last_q     <= !second_q && head_i.last_of_record;
      ts_q       <= is_rec ? head_i.timestamp_ms : '0;
      len_q      <= is_rec ? head_i.record_length : '0;
      off_q      <= is_rec ? head_i.byte_offset : '0;
      run_last_q <= run_last;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.status          = status_q;
  assign out_o.payload_byte    = byte_q;
  assign out_o.timestamp_ms    = ts_q;
  assign out_o.first_of_record = first_q;
  assign out_o.last_of_record  = last_q;
  assign out_o.record_length   = len_q;
  assign out_o.byte_offset     = off_q;
  assign out_o.last_of_run     = run_last_q;

endmodule
